// ===== hdl/tsi_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and codes of the timestamped sample interpolator.
package tsi_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int IDX_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int TIME_W        = 32;
    localparam int VAL_W         = 32;

    typedef struct packed {
        logic [TIME_W-1:0]        stamp;
        logic signed [VAL_W-1:0]  value;
    } t_sample;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_INTERP     = 3'd1,
        CMD_FIND_FIRST = 3'd2,
        CMD_FIND_LAST  = 3'd3,
        CMD_TRUNCATE   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_CLEARED   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_BLEND
    } t_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_FIN
    } t_blend_state;

endpackage

// ===== hdl/tsi_cell.sv =====
`timescale 1ns / 1ps
// One history cell: holds a sample, loads a new one or takes its neighbor's.
module tsi_cell (
    input  logic               i_clk,
    input  tsi_pkg::t_cell_ctl i_ctl,
    input  tsi_pkg::t_sample   i_neighbor,
    input  tsi_pkg::t_sample   i_load_data,
    output tsi_pkg::t_sample   o_sample
);
    import tsi_pkg::*;

    t_sample r_sample;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sample <= i_load_data;
        end else if (i_ctl.shift) begin
            r_sample <= i_neighbor;
        end
    end

    assign o_sample = r_sample;

endmodule

// ===== hdl/tsi_blend.sv =====
`timescale 1ns / 1ps
// Serial blend unit: v1 + a*(v2-v1)/(a+b), shift-add multiply then restoring divide.
module tsi_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic signed [tsi_pkg::VAL_W-1:0]  i_v1,
    input  logic signed [tsi_pkg::VAL_W-1:0]  i_v2,
    input  logic        [tsi_pkg::TIME_W-1:0] i_a,
    input  logic        [tsi_pkg::TIME_W-1:0] i_b,
    output logic                        o_done,
    output logic signed [tsi_pkg::VAL_W-1:0]  o_result
);
    import tsi_pkg::*;

    localparam int MAG_W  = VAL_W + 1;
    localparam int DEN_W  = TIME_W + 1;
    localparam int PROD_W = TIME_W + MAG_W;
    localparam int BASE_W = VAL_W + 3;

    t_blend_state              r_st;
    logic [6:0]                r_step;
    logic [TIME_W-1:0]         r_a;
    logic [MAG_W-1:0]          r_mag;
    logic                      r_neg;
    logic signed [VAL_W-1:0]   r_v1;
    logic [DEN_W-1:0]          r_den;
    logic [PROD_W-1:0]         r_acc;
    logic [DEN_W-1:0]          r_rem;
    logic                      r_done;
    logic signed [VAL_W-1:0]   r_result;

    logic signed [MAG_W-1:0]   diff;
    logic [DEN_W:0]            trial;
    logic                      qbit;
    logic signed [BASE_W-1:0]  v1_ext;
    logic signed [BASE_W-1:0]  q_ext;
    logic signed [BASE_W-1:0]  base;
    logic signed [BASE_W-1:0]  fixed;

    always_comb begin
        diff   = MAG_W'(i_v2) - MAG_W'(i_v1);
        trial  = {r_rem, r_acc[PROD_W-1]};
        qbit   = (trial >= {1'b0, r_den});
        v1_ext = BASE_W'(r_v1);
        q_ext  = $signed({{(BASE_W-MAG_W){1'b0}}, r_acc[MAG_W-1:0]});
        base   = r_neg ? (v1_ext - q_ext) : (v1_ext + q_ext);
        fixed  = base;
        // truncate toward zero when the sum crosses zero with a remainder
        if (r_rem != '0) begin
            if (!r_neg && base[BASE_W-1]) begin
                fixed = base + BASE_W'(1);
            end else if (r_neg && !base[BASE_W-1] && base != '0) begin
                fixed = base - BASE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= B_IDLE;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                B_IDLE: begin
                    if (i_go) begin
                        r_a    <= i_a;
                        r_v1   <= i_v1;
                        r_neg  <= diff[MAG_W-1];
                        r_mag  <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
                        r_den  <= DEN_W'(i_a) + DEN_W'(i_b);
                        r_acc  <= '0;
                        r_step <= '0;
                        r_st   <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_acc  <= {r_acc[PROD_W-2:0], 1'b0}
                              + (r_mag[MAG_W-1] ? PROD_W'(r_a) : '0);
                    r_mag  <= {r_mag[MAG_W-2:0], 1'b0};
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'(MAG_W - 1)) begin
                        r_step <= '0;
                        r_rem  <= '0;
                        r_st   <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem  <= qbit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                    r_acc  <= {r_acc[PROD_W-2:0], qbit};
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'(PROD_W - 1)) begin
                        r_st <= B_FIN;
                    end
                end
                B_FIN: begin
                    r_result <= fixed[VAL_W-1:0];
                    r_done   <= 1'b1;
                    r_st     <= B_IDLE;
                end
                default: begin
                    r_st <= B_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hdl/timestamped_sample_interpolator.sv =====
`timescale 1ns / 1ps
// Top level: ring of sample cells, scan sequencer and result register.
// Append, unknown commands and commands on an empty history give their result in
//   the cycle after the request is taken.
// Find, truncate and clamped interpolation: the ring scan, the decide state and the
//   result register; a blended interpolation adds the serial multiply and divide
//   in the blend unit.
// Throughput: append, unknown and empty-history commands never raise busy, so a
//   request can follow every cycle; a scan or blend holds busy until its result.
// Each result strobes for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) empties the history; cell contents are kept.
module timestamped_sample_interpolator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_command,
    input  logic [tsi_pkg::TIME_W-1:0]         i_sample_time,
    input  logic signed [tsi_pkg::VAL_W-1:0]   i_sample_value,
    output logic                               o_result_valid,
    output logic signed [tsi_pkg::VAL_W-1:0]   o_result_value,
    output logic [tsi_pkg::IDX_W-1:0]          o_result_index,
    output logic [tsi_pkg::CNT_W-1:0]          o_entry_count,
    output logic [1:0]                         o_status
);
    import tsi_pkg::*;

    // ---------------------------------------------------------------
    // Sequencer registers
    // ---------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_k, n_k;            // scan step = entry position at cell 0
    logic [2:0]             r_cmd, n_cmd;
    logic [TIME_W-1:0]      r_qt, n_qt;          // query time
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_fidx, n_fidx;      // first entry at/after query
    logic [IDX_W-1:0]       r_lastle, n_lastle;  // last entry at/before query
    t_sample                r_first, n_first;
    t_sample                r_last, n_last;
    t_sample                r_hit, n_hit;
    t_sample                r_prev, n_prev;
    t_sample                r_before, n_before;  // entry ahead of the hit

    logic                   r_ov, n_ov;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    t_status                r_st, n_st;

    // ---------------------------------------------------------------
    // Ring of cells: cell 0 holds the oldest entry while idle. A scan
    // rotates the ring by one every cycle for a full turn, so entry k
    // shows at cell 0 in step k and the ring ends aligned again.
    // ---------------------------------------------------------------
    t_sample                cells [HISTORY_DEPTH];
    t_cell_ctl              ctl   [HISTORY_DEPTH];
    t_sample                new_sample;
    t_sample                head;
    logic                   full;
    logic                   do_append;
    logic                   scanning;

    assign new_sample = '{stamp: i_sample_time, value: i_sample_value};
    assign head       = cells[0];
    assign full       = (r_count == CNT_W'(HISTORY_DEPTH));
    assign do_append  = (r_state == S_IDLE) && start && (i_command == CMD_APPEND);
    assign scanning   = (r_state == S_SCAN);

    for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
        // full append drops the oldest: shift down, new sample enters at the top
        assign ctl[g].shift = scanning || (do_append && full);
        if (g == HISTORY_DEPTH - 1) begin : g_top
            assign ctl[g].load = do_append && (full || r_count[IDX_W-1:0] == IDX_W'(g));
        end else begin : g_mid
            assign ctl[g].load = do_append && !full && (r_count[IDX_W-1:0] == IDX_W'(g));
        end

        tsi_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl[g]),
            .i_neighbor  (cells[(g + 1) % HISTORY_DEPTH]),
            .i_load_data (new_sample),
            .o_sample    (cells[g])
        );
    end

    // ---------------------------------------------------------------
    // Blend unit
    // ---------------------------------------------------------------
    logic                    blend_go;
    logic                    blend_done;
    logic signed [VAL_W-1:0] blend_res;
    logic [TIME_W-1:0]       blend_a;
    logic [TIME_W-1:0]       blend_b;

    assign blend_a = r_qt - r_before.stamp;
    assign blend_b = r_hit.stamp - r_qt;

    tsi_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (blend_go),
        .i_v1     (r_before.value),
        .i_v2     (r_hit.value),
        .i_a      (blend_a),
        .i_b      (blend_b),
        .o_done   (blend_done),
        .o_result (blend_res)
    );

    // ---------------------------------------------------------------
    // Next state and results
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] k_ext;
    logic [CNT_W-1:0] cnt_m1;
    logic             active;

    assign k_ext  = {{(CNT_W-IDX_W){1'b0}}, r_k};
    assign cnt_m1 = r_count - CNT_W'(1);
    assign active = (k_ext < r_count);

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_cmd    = r_cmd;
        n_qt     = r_qt;
        n_count  = r_count;
        n_found  = r_found;
        n_fidx   = r_fidx;
        n_lastle = r_lastle;
        n_first  = r_first;
        n_last   = r_last;
        n_hit    = r_hit;
        n_prev   = r_prev;
        n_before = r_before;
        n_ov     = 1'b0;
        n_val    = '0;
        n_idx    = '0;
        n_cnt    = r_count;
        n_st     = ST_OK;
        blend_go = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_command;
                    n_qt  = i_sample_time;
                    case (i_command)
                        CMD_APPEND: begin
                            n_count = full ? r_count : r_count + CNT_W'(1);
                            n_ov    = 1'b1;
                            n_idx   = full ? IDX_W'(HISTORY_DEPTH - 1) : r_count[IDX_W-1:0];
                            n_cnt   = n_count;
                        end
                        default: begin
                            if (i_command inside {[CMD_INTERP:CMD_TRUNCATE]}) begin
                                if (r_count == '0) begin
                                    n_ov = 1'b1;
                                    n_st = ST_EMPTY;
                                end else begin
                                    n_state  = S_SCAN;
                                    n_k      = '0;
                                    n_found  = 1'b0;
                                    n_lastle = '0;
                                end
                            end else begin
                                // unknown code: answer and change nothing
                                n_ov = 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (active) begin
                    if (head.stamp >= r_qt && !r_found) begin
                        n_found  = 1'b1;
                        n_fidx   = r_k;
                        n_hit    = head;
                        n_before = r_prev;
                    end
                    if (r_k != '0 && head.stamp <= r_qt) begin
                        n_lastle = r_k;
                    end
                    if (k_ext == cnt_m1) begin
                        n_last = head;
                    end
                end
                if (r_k == '0) begin
                    n_first = head;
                end
                n_prev = head;
                n_k    = r_k + IDX_W'(1);
                if (r_k == IDX_W'(HISTORY_DEPTH - 1)) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_state = S_IDLE;
                n_ov    = 1'b1;
                case (r_cmd)
                    CMD_INTERP: begin
                        // clamp at either end, else blend the pair around the query
                        if (r_qt <= r_first.stamp) begin
                            n_val = r_first.value;
                        end else if (r_qt > r_last.stamp) begin
                            n_val = r_last.value;
                        end else begin
                            n_ov     = 1'b0;
                            blend_go = 1'b1;
                            n_state  = S_BLEND;
                        end
                    end
                    CMD_FIND_FIRST: begin
                        if (r_found) begin
                            n_idx = r_fidx;
                        end else begin
                            n_st = ST_NOT_FOUND;
                        end
                    end
                    CMD_FIND_LAST: begin
                        n_idx = r_lastle;
                    end
                    CMD_TRUNCATE: begin
                        if (r_qt > r_last.stamp) begin
                            n_idx = cnt_m1[IDX_W-1:0];
                        end else if (r_qt < r_first.stamp) begin
                            n_count = '0;
                            n_cnt   = '0;
                            n_st    = ST_CLEARED;
                        end else begin
                            // keep everything up to the last entry at/before the query
                            n_count = {{(CNT_W-IDX_W){1'b0}}, r_lastle} + CNT_W'(1);
                            n_cnt   = n_count;
                            n_idx   = r_lastle;
                        end
                    end
                    default: begin
                        n_st = ST_OK;
                    end
                endcase
            end

            S_BLEND: begin
                if (blend_done) begin
                    n_ov    = 1'b1;
                    n_val   = blend_res;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_qt     <= n_qt;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
        r_lastle <= n_lastle;
        r_first  <= n_first;
        r_last   <= n_last;
        r_hit    <= n_hit;
        r_prev   <= n_prev;
        r_before <= n_before;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_st     <= n_st;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_ov;
    assign o_result_value = r_val;
    assign o_result_index = r_idx;
    assign o_entry_count  = r_cnt;
    assign o_status       = r_st;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HISTORY_DEPTH))
        else $error("history count above depth");

    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_k == '0))
        else $error("ring not aligned while idle");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_valid || busy))
        else $error("request neither answered nor in progress");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_EMPTY || o_status == ST_CLEARED))
        |-> (o_entry_count == '0))
        else $error("empty status with entries held");

endmodule
